// File: src/ple_pkg.sv
package ple_pkg;

  // Field widths of one item
  localparam int MODE_W  = 3;
  localparam int VALUE_W = 32;
  localparam int POS_W   = 5;
  localparam int STAT_W  = 2;

  // Input tdata: value, position, padded to whole bytes
  localparam int IN_DATA_W = ((VALUE_W + POS_W + 7) / 8) * 8;

  // Operation codes carried in the input tuser
  typedef enum logic [MODE_W-1:0] {
    MODE_INS_FRONT = 3'd0,
    MODE_INS_END   = 3'd1,
    MODE_INS_POS   = 3'd2,
    MODE_DEL_FRONT = 3'd3,
    MODE_DEL_END   = 3'd4,
    MODE_DEL_POS   = 3'd5,
    MODE_SIZE      = 3'd6,
    MODE_MIDDLE    = 3'd7
  } mode_t;

  // Result status codes
  typedef enum logic [STAT_W-1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_FULL   = 2'd2,
    ST_BADPOS = 2'd3
  } status_t;

  // Operation applied to every cell of the chain
  typedef enum logic [1:0] {
    CELL_HOLD = 2'd0,
    CELL_INS  = 2'd1,
    CELL_DEL  = 2'd2
  } cell_op_t;

endpackage

// File: src/ple_cell.sv
module ple_cell
  import ple_pkg::*;
#(
  parameter int IDX = 0,
  parameter int IW  = 4
) (
  input  logic               clk,
  input  cell_op_t           op,
  input  logic [IW-1:0]      at,
  input  logic [VALUE_W-1:0] ins_value,
  input  logic [VALUE_W-1:0] left,
  input  logic [VALUE_W-1:0] right,
  output logic [VALUE_W-1:0] data
);

  localparam logic [IW-1:0] MY_IDX = IW'(IDX);

  // Insert: cells past the gap take the left neighbor, the gap takes the new value.
  // Delete: cells from the gap on take the right neighbor.
  always_ff @(posedge clk) begin
    case (op)
      CELL_INS: begin
        if (MY_IDX == at) begin
          data <= ins_value;
        end else if (MY_IDX > at) begin
          data <= left;
        end
      end
      CELL_DEL: begin
        if (MY_IDX >= at) begin
          data <= right;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// File: src/positional_list_engine_unit.sv
// Ordered list of up to DEPTH signed 32-bit values held in a chain of cells,
// front at cell 0. Every item (operation in s_axis_tuser) is applied when it
// is accepted: the cells from the gap on shift together toward the end on an
// insert or toward the front on a delete, and the single result item appears
// in the output register on the cycle after the item is accepted. The block
// takes one item per cycle as long as the output register is empty or being
// drained in that same cycle; the read of the deleted or middle value through
// a DEPTH-way select of the cells sets the cycle's logic depth. Cell contents
// need no reset; only the entry count and the output valid are cleared.
module positional_list_engine_unit
  import ple_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // [31:0] value, [36:32] position, rest zero
  input  logic [IN_DATA_W-1:0] s_axis_tdata,
  // [2:0] mode
  input  logic [MODE_W-1:0]   s_axis_tuser,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // [1:0] status, [33:2] result_value, then entry_count, rest zero
  output logic [((STAT_W + VALUE_W + $clog2(DEPTH + 1) + 7) / 8) * 8 - 1:0] m_axis_tdata
);

  localparam int CW    = $clog2(DEPTH + 1);
  localparam int IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CMPW  = ((CW > POS_W) ? CW : POS_W) + 1;
  localparam int OUT_W = ((STAT_W + VALUE_W + CW + 7) / 8) * 8;
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  logic [CW-1:0]      count;
  logic [CW-1:0]      count_next;
  logic [VALUE_W-1:0] ent [DEPTH];

  logic               accept;
  mode_t              mode;
  logic [VALUE_W-1:0] in_value;
  logic [POS_W-1:0]   in_pos;
  logic               is_full;
  logic               is_empty;
  logic               pos_bad_ins;
  logic               pos_bad_del;
  logic [IW-1:0]      pos_idx;
  logic [IW-1:0]      last_idx;

  status_t            status;
  cell_op_t           op;
  cell_op_t           cell_op;
  logic [IW-1:0]      at;
  logic [IW-1:0]      rd_idx;
  logic               rd_en;
  logic [VALUE_W-1:0] res_value;
  logic [OUT_W-1:0]   out_word;

  // Input unpacking and handshake
  assign accept   = s_axis_tvalid & s_axis_tready;
  assign s_axis_tready = ~m_axis_tvalid | m_axis_tready;
  assign mode     = mode_t'(s_axis_tuser);
  assign in_value = s_axis_tdata[VALUE_W-1:0];
  assign in_pos   = s_axis_tdata[VALUE_W +: POS_W];

  // Bounds checks
  assign is_full     = (count >= FULL_CNT);
  assign is_empty    = (count == '0);
  assign pos_bad_ins = (in_pos == '0) || (CMPW'(in_pos) > (CMPW'(count) + CMPW'(1)));
  assign pos_bad_del = (in_pos == '0) || (CMPW'(in_pos) > CMPW'(count));
  assign pos_idx     = IW'(in_pos - POS_W'(1));
  assign last_idx    = IW'(count - CW'(1));

  // Operation decode
  always_comb begin
    status = ST_OK;
    op     = CELL_HOLD;
    at     = '0;
    rd_idx = '0;
    rd_en  = 1'b0;
    case (mode)
      MODE_INS_FRONT: begin
        if (is_full) status = ST_FULL;
        else op = CELL_INS;
      end
      MODE_INS_END: begin
        if (is_full) begin
          status = ST_FULL;
        end else begin
          op = CELL_INS;
          at = IW'(count);
        end
      end
      MODE_INS_POS: begin
        if (is_full) begin
          status = ST_FULL;
        end else if (pos_bad_ins) begin
          status = ST_BADPOS;
        end else begin
          op = CELL_INS;
          at = pos_idx;
        end
      end
      MODE_DEL_FRONT: begin
        if (is_empty) begin
          status = ST_EMPTY;
        end else begin
          op    = CELL_DEL;
          rd_en = 1'b1;
        end
      end
      MODE_DEL_END: begin
        if (is_empty) begin
          status = ST_EMPTY;
        end else begin
          op     = CELL_DEL;
          at     = last_idx;
          rd_idx = last_idx;
          rd_en  = 1'b1;
        end
      end
      MODE_DEL_POS: begin
        if (is_empty) begin
          status = ST_EMPTY;
        end else if (pos_bad_del) begin
          status = ST_BADPOS;
        end else begin
          op     = CELL_DEL;
          at     = pos_idx;
          rd_idx = pos_idx;
          rd_en  = 1'b1;
        end
      end
      MODE_MIDDLE: begin
        if (is_empty) begin
          status = ST_EMPTY;
        end else begin
          rd_idx = IW'(count >> 1);
          rd_en  = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // Count after this item
  always_comb begin
    case (op)
      CELL_INS: count_next = count + CW'(1);
      CELL_DEL: count_next = count - CW'(1);
      default:  count_next = count;
    endcase
  end

  assign cell_op   = accept ? op : CELL_HOLD;
  assign res_value = rd_en ? ent[rd_idx] : '0;

  // Cell chain
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [VALUE_W-1:0] left_data;
    logic [VALUE_W-1:0] right_data;
    if (i == 0) begin : g_first
      assign left_data = in_value;
    end else begin : g_mid_l
      assign left_data = ent[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_data = '0;
    end else begin : g_mid_r
      assign right_data = ent[i+1];
    end
    ple_cell #(
      .IDX (i),
      .IW  (IW)
    ) u_cell (
      .clk       (clk),
      .op        (cell_op),
      .at        (at),
      .ins_value (in_value),
      .left      (left_data),
      .right     (right_data),
      .data      (ent[i])
    );
  end

  // Result packing
  always_comb begin
    out_word = '0;
    out_word[STAT_W-1:0]            = status;
    out_word[STAT_W +: VALUE_W]     = res_value;
    out_word[STAT_W + VALUE_W +: CW] = count_next;
  end

  // Count and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      count         <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (accept) begin
        count         <= count_next;
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) m_axis_tdata <= out_word;
  end

endmodule
